// File: rtl/lsa_pkg.sv
// Shared types and constants of the lease slot allocator.
// Used by every module of the block; depends on nothing.
package lsa_pkg;

    localparam int MODE_W     = 2;
    localparam int QUERY_W    = 9;
    localparam int STATUS_W   = 2;
    localparam int ID_W       = 11;
    localparam int AGE_W      = 8;
    localparam int COUNT_W    = 10;
    localparam int LEASE_W    = 8;
    localparam int ID_BASE_W  = 10;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 10;

    // Input item kinds.
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    // Result kinds.
    localparam logic [STATUS_W-1:0] STATUS_GRANT = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TICK  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_QUERY = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_LEASE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ID_BASE = 1'b1;

    localparam logic [LEASE_W-1:0]   LEASE_RESET   = 8'd14;
    localparam logic [ID_BASE_W-1:0] ID_BASE_RESET = 10'd89;

    // Free list commands from the sequencer.
    typedef struct packed {
        logic init_we;
        logic push;
        logic pop;
        logic rd_en;
    } t_fl_ctrl;

    // Enables of a simple dual-port memory.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_en;

endpackage

// File: rtl/lease_slot_allocator_unit.sv
// Lease slot allocator: lends slot ids from a FIFO free list and takes them
// back after a lease of ticks. Items enter on the s_axis channel: tuser holds
// the mode, tdata the queried slot. Each item except mode three gives one
// result on the m_axis channel: tuser holds the status, tdata the slot id,
// the age and the free count. Configuration writes go through i_cfg_we,
// i_cfg_addr and i_cfg_wdata and take effect at once.
// After reset a clearing sweep over every slot fills the free list and
// zeroes all ages; no item is accepted meanwhile.
// An allocate or query passes through its own state and then ST_DONE before a
// valid result (an allocate on an empty list goes straight to ST_DONE), set by
// the registered reads of the free list and the age memory. A tick walks all
// slots through one shared compare and increment unit, one slot a cycle.
// One item is at work at a time; tready is high only while the sequencer is
// idle. The result register lets the next item be accepted while a result
// waits; if the receiver stalls longer, the finished item waits in the
// sequencer and the input stays not ready until the result register frees.
// Depends on lsa_pkg, lsa_free_list and lsa_age_mem.
module lease_slot_allocator_unit #(
    parameter int NUM_SLOTS = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input transaction.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [15:0]                       i_s_axis_tdata,   // slot_query[8:0]
    input  logic [lsa_pkg::MODE_W-1:0]        i_s_axis_tuser,   // mode[1:0]
    // Result transaction.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [31:0]                       o_m_axis_tdata,   // slot_id[10:0],
                                                                // age[18:11],
                                                                // free_count[28:19]
    output logic [lsa_pkg::STATUS_W-1:0]      o_m_axis_tuser,   // status[1:0]
    // Configuration writes.
    input  logic                              i_cfg_we,
    input  logic [lsa_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [lsa_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_QUERY,
        ST_TICK,
        ST_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [SLOT_W-1:0]               r_idx;
    logic [lsa_pkg::QUERY_W-1:0]     r_q;
    logic                            r_q_ok;
    logic [lsa_pkg::LEASE_W-1:0]     r_lease;
    logic [lsa_pkg::ID_BASE_W-1:0]   r_id_base;
    logic [lsa_pkg::STATUS_W-1:0]    r_res_status;
    logic [lsa_pkg::ID_W-1:0]        r_res_id;
    logic [lsa_pkg::AGE_W-1:0]       r_res_age;
    logic                            r_m_valid;
    logic [lsa_pkg::STATUS_W-1:0]    r_m_status;
    logic [lsa_pkg::ID_W-1:0]        r_m_id;
    logic [lsa_pkg::AGE_W-1:0]       r_m_age;
    logic [lsa_pkg::COUNT_W-1:0]     r_m_count;

    lsa_pkg::t_fl_ctrl               fl_ctrl;
    logic [SLOT_W-1:0]               fl_head_data;
    logic [CNT_W-1:0]                fl_total;
    logic                            fl_empty;
    logic                            fl_full;

    lsa_pkg::t_mem_en                age_en;
    logic [SLOT_W-1:0]               age_waddr;
    logic [lsa_pkg::AGE_W-1:0]       age_wdata;
    logic [SLOT_W-1:0]               age_raddr;
    logic [lsa_pkg::AGE_W-1:0]       age_rdata;

    logic                            s_hs;
    logic [lsa_pkg::MODE_W-1:0]      in_mode;
    logic [lsa_pkg::QUERY_W-1:0]     in_q;
    logic                            in_q_ok;
    logic [SLOT_W-1:0]               alloc_slot;
    logic                            age_live;
    logic                            age_keep;
    logic [lsa_pkg::AGE_W-1:0]       age_inc;
    logic [lsa_pkg::ID_W-1:0]        id_operand;
    logic [lsa_pkg::ID_W-1:0]        id_sum;
    logic                            out_free;

    lsa_free_list #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_free_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (fl_ctrl),
        .i_init_addr (r_idx),
        .i_push_data (r_idx),
        .o_head_data (fl_head_data),
        .o_total     (fl_total),
        .o_empty     (fl_empty),
        .o_full      (fl_full)
    );

    lsa_age_mem #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_age_mem (
        .i_clk   (i_clk),
        .i_en    (age_en),
        .i_waddr (age_waddr),
        .i_wdata (age_wdata),
        .i_raddr (age_raddr),
        .o_rdata (age_rdata)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_hs            = i_s_axis_tvalid && o_s_axis_tready;
    assign in_mode         = i_s_axis_tuser;
    assign in_q            = i_s_axis_tdata[lsa_pkg::QUERY_W-1:0];
    assign in_q_ok         = (32'(in_q) < NUM_SLOTS);
    assign out_free        = !r_m_valid || i_m_axis_tready;

    // A list entry that is not a valid slot is granted as slot zero.
    assign alloc_slot = (32'(fl_head_data) >= NUM_SLOTS) ? '0 : fl_head_data;

    // Shared age unit used for every slot of a tick walk.
    assign age_live = (age_rdata != '0);
    assign age_keep = (age_rdata < r_lease);
    assign age_inc  = age_rdata + 1'b1;

    // Shared id adder for grants and queries.
    assign id_operand = (r_state == ST_ALLOC) ? lsa_pkg::ID_W'(alloc_slot)
                                              : lsa_pkg::ID_W'(r_q);
    assign id_sum     = lsa_pkg::ID_W'(r_id_base) + id_operand;

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m_status;
    assign o_m_axis_tdata  = {3'b000, r_m_count, r_m_age, r_m_id};

    always_comb begin
        n_state   = r_state;
        fl_ctrl   = '0;
        age_en    = '0;
        age_waddr = r_idx;
        age_wdata = '0;
        age_raddr = '0;
        unique case (r_state)
            ST_CLEAR: begin
                fl_ctrl.init_we = 1'b1;
                age_en.we       = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_hs) begin
                    case (in_mode)
                        lsa_pkg::MODE_TICK: begin
                            age_en.re = 1'b1;
                            n_state   = ST_TICK;
                        end
                        lsa_pkg::MODE_ALLOC: begin
                            if (fl_empty) begin
                                n_state = ST_DONE;
                            end else begin
                                fl_ctrl.rd_en = 1'b1;
                                n_state       = ST_ALLOC;
                            end
                        end
                        lsa_pkg::MODE_QUERY: begin
                            age_en.re = 1'b1;
                            age_raddr = in_q_ok ? SLOT_W'(in_q) : '0;
                            n_state   = ST_QUERY;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                fl_ctrl.pop = 1'b1;
                age_en.we   = 1'b1;
                age_waddr   = alloc_slot;
                age_wdata   = lsa_pkg::AGE_W'(1);
                n_state     = ST_DONE;
            end
            ST_QUERY: begin
                n_state = ST_DONE;
            end
            ST_TICK: begin
                // Slot r_idx is written back while slot r_idx + 1 is read.
                if (age_live) begin
                    age_en.we = 1'b1;
                    if (age_keep) begin
                        age_wdata = age_inc;
                    end else begin
                        fl_ctrl.push = 1'b1;
                    end
                end
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DONE;
                end else begin
                    age_en.re = 1'b1;
                    age_raddr = r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lease   <= lsa_pkg::LEASE_RESET;
            r_id_base <= lsa_pkg::ID_BASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lsa_pkg::CFG_LEASE:   r_lease   <= i_cfg_wdata[lsa_pkg::LEASE_W-1:0];
                lsa_pkg::CFG_ID_BASE: r_id_base <= i_cfg_wdata[lsa_pkg::ID_BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                end
                ST_IDLE: begin
                    r_idx  <= '0;
                    r_q    <= in_q;
                    r_q_ok <= in_q_ok;
                    r_res_status <= lsa_pkg::STATUS_EMPTY;
                    r_res_id     <= '0;
                    r_res_age    <= '0;
                end
                ST_ALLOC: begin
                    r_res_status <= lsa_pkg::STATUS_GRANT;
                    r_res_id     <= id_sum;
                    r_res_age    <= lsa_pkg::AGE_W'(1);
                end
                ST_QUERY: begin
                    r_res_status <= lsa_pkg::STATUS_QUERY;
                    r_res_id     <= id_sum;
                    r_res_age    <= r_q_ok ? age_rdata : '0;
                end
                ST_TICK: begin
                    r_idx        <= r_idx + 1'b1;
                    r_res_status <= lsa_pkg::STATUS_TICK;
                    r_res_id     <= '0;
                    r_res_age    <= '0;
                end
                ST_DONE: begin
                    // The free count is taken after this item's list updates.
                    if (out_free) begin
                        r_m_status <= r_res_status;
                        r_m_id     <= r_res_id;
                        r_m_age    <= r_res_age;
                        r_m_count  <= lsa_pkg::COUNT_W'(fl_total);
                    end
                end
                default: begin
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_hs && (in_mode == lsa_pkg::MODE_TICK || in_mode == lsa_pkg::MODE_ALLOC ||
                  in_mode == lsa_pkg::MODE_QUERY)) |=> !o_s_axis_tready)
        else $error("input ready right after an item was accepted");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fl_ctrl.pop |-> !fl_empty)
        else $error("free list popped while empty");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fl_ctrl.push |-> !fl_full)
        else $error("free list pushed while full");

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fl_ctrl.push && fl_ctrl.pop))
        else $error("free list pushed and popped in one cycle");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(fl_total) <= NUM_SLOTS)
        else $error("free count above the number of slots");

    a_grant_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALLOC) |=> (r_res_age == lsa_pkg::AGE_W'(1)))
        else $error("granted slot reported with an age other than one");
`endif

endmodule

// File: rtl/lsa_free_list.sv
// Circular FIFO free list of slot indexes, with head, tail and fill count.
// Depends on lsa_pkg for the command struct.
module lsa_free_list #(
    parameter int NUM_SLOTS = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lsa_pkg::t_fl_ctrl               i_ctrl,
    input  logic [$clog2(NUM_SLOTS)-1:0]    i_init_addr,
    input  logic [$clog2(NUM_SLOTS)-1:0]    i_push_data,
    output logic [$clog2(NUM_SLOTS)-1:0]    o_head_data,
    output logic [$clog2(NUM_SLOTS+1)-1:0]  o_total,
    output logic                            o_empty,
    output logic                            o_full
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(NUM_SLOTS - 1);

    logic [SLOT_W-1:0] r_list [NUM_SLOTS];
    logic [SLOT_W-1:0] r_head;
    logic [SLOT_W-1:0] r_tail;
    logic [CNT_W-1:0]  r_total;
    logic [SLOT_W-1:0] r_rdata;

    assign o_empty     = (r_total == '0);
    assign o_full      = (r_total == CNT_W'(NUM_SLOTS));
    assign o_total     = r_total;
    assign o_head_data = r_rdata;

    // Initial contents are written by the clearing sweep after reset.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.init_we) begin
            r_list[i_init_addr] <= i_init_addr;
        end else if (i_ctrl.push && !o_full) begin
            r_list[r_tail] <= i_push_data;
        end
        if (i_ctrl.rd_en) begin
            r_rdata <= r_list[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_total <= CNT_W'(NUM_SLOTS);
        end else begin
            if (i_ctrl.push && !o_full) begin
                r_tail  <= (r_tail == LAST_POS) ? '0 : r_tail + 1'b1;
                r_total <= r_total + 1'b1;
            end else if (i_ctrl.pop && !o_empty) begin
                r_head  <= (r_head == LAST_POS) ? '0 : r_head + 1'b1;
                r_total <= r_total - 1'b1;
            end
        end
    end

endmodule

// File: rtl/lsa_age_mem.sv
// Age memory: one age per slot, one write and one registered read a cycle.
// Depends on lsa_pkg for the enable struct and the age width.
module lsa_age_mem #(
    parameter int NUM_SLOTS = 512
) (
    input  logic                          i_clk,
    input  lsa_pkg::t_mem_en              i_en,
    input  logic [$clog2(NUM_SLOTS)-1:0]  i_waddr,
    input  logic [lsa_pkg::AGE_W-1:0]     i_wdata,
    input  logic [$clog2(NUM_SLOTS)-1:0]  i_raddr,
    output logic [lsa_pkg::AGE_W-1:0]     o_rdata
);

    logic [lsa_pkg::AGE_W-1:0] r_mem [NUM_SLOTS];
    logic [lsa_pkg::AGE_W-1:0] r_rdata;

    assign o_rdata = r_rdata;

    // Read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_en.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_en.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

endmodule
